/* rtl/bclr_pkg.sv */
// package: constants, register indexes and reset values for the button detector
package bclr_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int TIME_W          = 32;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int OUT_CNT_W       = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 2'd3;

  localparam logic             ENABLED_RST      = 1'b1;
  localparam logic [CFG_W-1:0] CLICK_WINDOW_RST = 16'd500;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] REPEAT_RST       = 16'd100;

  localparam logic LEVEL_RELEASED = 1'b1;
  localparam logic LEVEL_PRESSED  = 1'b0;

endpackage

/* rtl/bclr_in_if.sv */
// interface: sample channel carrying button level and timestamp
interface bclr_in_if
  import bclr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              level;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, output level, output time_ms, input ready);
  modport sink (input valid, input level, input time_ms, output ready);
endinterface

/* rtl/bclr_out_if.sv */
// interface: result channel carrying event and counter status
interface bclr_out_if
  import bclr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 changed;
  logic                 cur_level;
  logic [OUT_CNT_W-1:0] pushes;
  logic [OUT_CNT_W-1:0] clicks;
  logic                 is_long;
  logic [OUT_CNT_W-1:0] repeats;

  modport source (
    output valid, output changed, output cur_level, output pushes,
    output clicks, output is_long, output repeats, input ready
  );
  modport sink (
    input valid, input changed, input cur_level, input pushes,
    input clicks, input is_long, input repeats, output ready
  );
endinterface

/* rtl/button_click_long_repeat_detector_top.sv */
// Button multi-click, long-press and auto-repeat detector. Each transfer on
// in_ch is one button sample (level 1 released, 0 pressed, plus a millisecond
// timestamp) and yields exactly one result on out_ch. The block takes one
// sample per clock cycle while out_ch is not stalled; a result passes through
// the input register and then the result register, with the event logic and
// all state update between them. A stalled result stays in the result
// register while one more sample waits in the input register. The user must
// write configuration through cfg_we/cfg_index/cfg_data only while no sample
// is in flight; the block itself does not enforce this.
module button_click_long_repeat_detector_top
  import bclr_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bclr_in_if.sink              in_ch,
  bclr_out_if.source           out_ch
);

  localparam int EXT_W = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  // configuration
  logic             enabled;
  logic [CFG_W-1:0] click_window_ms;
  logic [CFG_W-1:0] long_press_ms;
  logic [CFG_W-1:0] repeat_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= ENABLED_RST;
      click_window_ms <= CLICK_WINDOW_RST;
      long_press_ms   <= LONG_PRESS_RST;
      repeat_ms       <= REPEAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLED:      enabled         <= cfg_data[0];
        REG_CLICK_WINDOW: click_window_ms <= cfg_data;
        REG_LONG_PRESS:   long_press_ms   <= cfg_data;
        REG_REPEAT:       repeat_ms       <= cfg_data;
        default:          ;
      endcase
    end
  end

  // input register
  logic              in_valid_r;
  logic              in_level_r;
  logic [TIME_W-1:0] in_time_r;
  logic              advance;

  assign advance     = in_valid_r && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_level_r <= in_ch.level;
      in_time_r  <= in_ch.time_ms;
    end
  end

  // detector state
  logic                   last_level;
  logic [TIME_W-1:0]      press_time;
  logic [TIME_W-1:0]      first_press_time;
  logic [COUNT_WIDTH-1:0] push_counter;
  logic                   long_flag;
  logic [COUNT_WIDTH-1:0] repeat_counter;

  logic                   last_level_next;
  logic [TIME_W-1:0]      press_time_next;
  logic [TIME_W-1:0]      first_press_time_next;
  logic [COUNT_WIDTH-1:0] push_counter_next;
  logic                   long_flag_next;
  logic [COUNT_WIDTH-1:0] repeat_counter_next;
  logic [COUNT_WIDTH-1:0] click_result_next;
  logic                   changed_next;

  logic [TIME_W-1:0]      since_first;
  logic [TIME_W-1:0]      since_press;
  logic [COUNT_WIDTH-1:0] push_inc;

  assign since_first = in_time_r - first_press_time;
  assign since_press = in_time_r - press_time;
  assign push_inc    = push_counter + CNT_ONE;

  always_comb begin
    last_level_next       = last_level;
    press_time_next       = press_time;
    first_press_time_next = first_press_time;
    push_counter_next     = push_counter;
    long_flag_next        = long_flag;
    repeat_counter_next   = repeat_counter;
    click_result_next     = '0;
    changed_next          = 1'b0;
    if (enabled) begin
      last_level_next = in_level_r;
      priority if (in_level_r == LEVEL_RELEASED) begin
        if (push_counter != '0 && since_first > TIME_W'(click_window_ms)) begin
          click_result_next = push_counter;
          push_counter_next = '0;
          changed_next      = 1'b1;
        end
        press_time_next     = '0;
        long_flag_next      = 1'b0;
        repeat_counter_next = '0;
        if (last_level == LEVEL_PRESSED) begin
          changed_next = 1'b1;
        end
      end else if (last_level == LEVEL_RELEASED) begin
        press_time_next   = in_time_r;
        push_counter_next = push_inc;
        if (push_inc == CNT_ONE) begin
          first_press_time_next = in_time_r;
        end
        changed_next = 1'b1;
      end else if (!long_flag) begin
        if (since_press > TIME_W'(long_press_ms)) begin
          long_flag_next  = 1'b1;
          press_time_next = in_time_r;
          changed_next    = 1'b1;
        end
      end else begin
        if (since_press > TIME_W'(repeat_ms)) begin
          repeat_counter_next = repeat_counter + CNT_ONE;
          press_time_next     = in_time_r;
          changed_next        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level       <= LEVEL_RELEASED;
      press_time       <= '0;
      first_press_time <= '0;
      push_counter     <= '0;
      long_flag        <= 1'b0;
      repeat_counter   <= '0;
    end else if (advance) begin
      last_level       <= last_level_next;
      press_time       <= press_time_next;
      first_press_time <= first_press_time_next;
      push_counter     <= push_counter_next;
      long_flag        <= long_flag_next;
      repeat_counter   <= repeat_counter_next;
    end
  end

  // result register
  logic [EXT_W-1:0] push_ext;
  logic [EXT_W-1:0] click_ext;
  logic [EXT_W-1:0] repeat_ext;

  assign push_ext   = EXT_W'(push_counter_next);
  assign click_ext  = EXT_W'(click_result_next);
  assign repeat_ext = EXT_W'(repeat_counter_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.changed   <= changed_next;
      out_ch.cur_level <= last_level_next;
      out_ch.pushes    <= push_ext[OUT_CNT_W-1:0];
      out_ch.clicks    <= click_ext[OUT_CNT_W-1:0];
      out_ch.is_long   <= long_flag_next;
      out_ch.repeats   <= repeat_ext[OUT_CNT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_clicks_mark_change: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.clicks != '0) |-> out_ch.changed)
    else $error("click report without change flag");

  a_repeat_needs_long: assert property (@(posedge clk) disable iff (rst)
    (repeat_counter != '0) |-> long_flag)
    else $error("repeat count outside a long press");

  a_released_not_long: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.cur_level == LEVEL_RELEASED) |-> !out_ch.is_long)
    else $error("long press flagged while released");

  a_stall_holds_sample: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (in_valid_r && out_ch.valid && !out_ch.ready))
    else $error("input stalled without a blocked result");
`endif

endmodule

/* verif/tb_top.sv */
// testbench: button click, long-press and repeat detector against a cycle-free status tracker
module tb_top;
  import bclr_pkg::*;

  localparam int ITEM_GOAL   = 1450;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic              level;
    logic [TIME_W-1:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic                 changed;
    logic                 cur_level;
    logic [OUT_CNT_W-1:0] pushes;
    logic [OUT_CNT_W-1:0] clicks;
    logic                 is_long;
    logic [OUT_CNT_W-1:0] repeats;
  } btn_status_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bclr_in_if  in_ch ();
  bclr_out_if out_ch ();

  button_click_long_repeat_detector_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  sample_t     sample_q[$];
  btn_status_t status_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          n_items = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  logic        in_taken = 1'b0;
  logic        line_idle = 1'b0;

  // tracker copy of the block state and registers
  logic                       trk_level;
  logic [TIME_W-1:0]          trk_press_t;
  logic [TIME_W-1:0]          trk_first_t;
  logic [COUNT_WIDTH_DEF-1:0] trk_pushes;
  logic                       trk_long;
  logic [COUNT_WIDTH_DEF-1:0] trk_repeats;
  logic                       reg_en;
  logic [CFG_W-1:0]           reg_win;
  logic [CFG_W-1:0]           reg_long;
  logic [CFG_W-1:0]           reg_rep;

  // stimulus-side register copies and time cursor
  logic              g_en;
  int                g_win;
  int                g_lp;
  int                g_rp;
  logic [TIME_W-1:0] now_ms;

  function automatic btn_status_t track_button(input logic lvl, input logic [TIME_W-1:0] now);
    btn_status_t       st;
    logic              prev;
    logic [TIME_W-1:0] since_first;
    logic [TIME_W-1:0] since_press;
    st = '0;
    if (reg_en) begin
      prev = trk_level;
      trk_level = lvl;
      since_first = now - trk_first_t;
      since_press = now - trk_press_t;
      if (lvl == LEVEL_RELEASED) begin
        if (trk_pushes != '0 && since_first > {16'd0, reg_win}) begin
          st.clicks = trk_pushes;
          trk_pushes = '0;
          st.changed = 1'b1;
        end
        trk_press_t = '0;
        trk_long = 1'b0;
        trk_repeats = '0;
        if (prev == LEVEL_PRESSED) st.changed = 1'b1;
      end else if (prev == LEVEL_RELEASED) begin
        trk_press_t = now;
        trk_pushes = trk_pushes + 1'b1;
        if (trk_pushes == 1) trk_first_t = now;
        st.changed = 1'b1;
      end else if (!trk_long) begin
        if (since_press > {16'd0, reg_long}) begin
          trk_long = 1'b1;
          trk_press_t = now;
          st.changed = 1'b1;
        end
      end else if (since_press > {16'd0, reg_rep}) begin
        trk_repeats = trk_repeats + 1'b1;
        trk_press_t = now;
        st.changed = 1'b1;
      end
    end
    st.cur_level = trk_level;
    st.pushes = trk_pushes;
    st.is_long = trk_long;
    st.repeats = trk_repeats;
    return st;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  function automatic int pick_idle(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    btn_status_t want;
    in_taken = !rst && in_ch.valid && in_ch.ready;
    if (rst) begin
      trk_level = LEVEL_RELEASED;
      trk_press_t = '0;
      trk_first_t = '0;
      trk_pushes = '0;
      trk_long = 1'b0;
      trk_repeats = '0;
      reg_en = ENABLED_RST;
      reg_win = CLICK_WINDOW_RST;
      reg_long = LONG_PRESS_RST;
      reg_rep = REPEAT_RST;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLED:      reg_en = cfg_data[0];
          REG_CLICK_WINDOW: reg_win = cfg_data;
          REG_LONG_PRESS:   reg_long = cfg_data;
          REG_REPEAT:       reg_rep = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t: result transfer with none pending, actual changed=%0b pushes=%0d",
                   $time, out_ch.changed, out_ch.pushes);
        end else begin
          want = status_q.pop_front();
          check_field("changed", want.changed, out_ch.changed);
          check_field("cur_level", want.cur_level, out_ch.cur_level);
          check_field("pushes", want.pushes, out_ch.pushes);
          check_field("clicks", want.clicks, out_ch.clicks);
          check_field("is_long", want.is_long, out_ch.is_long);
          check_field("repeats", want.repeats, out_ch.repeats);
        end
      end
      if (in_taken) status_q.push_back(track_button(in_ch.level, in_ch.time_ms));
    end
  end

  always @(posedge clk) begin
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      cycles <= cycles + 1;
    end
  end

  always @(negedge clk) begin
    sample_t pending;
    line_idle = (sample_q.size() == 0) && !in_ch.valid && (status_q.size() == 0);
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
    end else if (gap_left > 0) begin
      gap_left--;
      in_ch.valid <= 1'b0;
    end else if (sample_q.size() > 0) begin
      pending = sample_q.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.level <= pending.level;
      in_ch.time_ms <= pending.time_ms;
      gap_left = pick_idle(in_idle_pct);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_idle(out_stall_pct);
    end
  end

  task automatic put_sample(input logic lvl, input logic [TIME_W-1:0] step);
    sample_t s;
    now_ms = now_ms + step;
    s.level = lvl;
    s.time_ms = now_ms;
    sample_q.push_back(s);
    if (g_en) n_items++;
  endtask

  task automatic wait_idle();
    line_idle = 1'b0;
    wait (line_idle);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_regs(input logic en, input int win, input int lp, input int rp);
    cfg_we <= 1'b1;
    cfg_index <= REG_ENABLED;
    cfg_data <= {{(CFG_W-1){1'b0}}, en};
    @(negedge clk);
    cfg_index <= REG_CLICK_WINDOW;
    cfg_data <= win[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_data <= lp[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_REPEAT;
    cfg_data <= rp[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    g_en = en;
    g_win = win;
    g_lp = lp;
    g_rp = rp;
  endtask

  function automatic logic [TIME_W-1:0] near(input int thr);
    case ($urandom_range(0, 4))
      0: return thr;
      1: return thr + 1;
      2: return $urandom_range(0, thr);
      3: return thr + $urandom_range(2, 300);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic int pick_reg();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 'hFFFF;
      2, 3: return $urandom_range(1, 1500);
      default: return $urandom_range(0, 'hFFFF);
    endcase
  endfunction

  task automatic gesture();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        put_sample(LEVEL_PRESSED, $urandom_range(0, 30));
        put_sample(LEVEL_RELEASED, $urandom_range(0, 30));
      end
      repeat ($urandom_range(1, 2)) put_sample(LEVEL_RELEASED, near(g_win));
    end else if (kind <= 6) begin
      put_sample(LEVEL_PRESSED, $urandom_range(0, 30));
      put_sample(LEVEL_PRESSED, near(g_lp));
      repeat ($urandom_range(0, 7)) put_sample(LEVEL_PRESSED, near(g_rp));
      put_sample(LEVEL_RELEASED, $urandom_range(0, 30));
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, 4)) put_sample(1'($urandom_range(0, 1)), $urandom());
    end else begin
      repeat ($urandom_range(2, 6)) begin
        put_sample(1'($urandom_range(0, 1)), $urandom_range(0, 20));
      end
    end
  endtask

  initial begin
    int stop_at;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLED;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.level = LEVEL_RELEASED;
    in_ch.time_ms = '0;
    out_ch.ready = 1'b0;
    now_ms = '0;
    g_en = ENABLED_RST;
    g_win = int'(CLICK_WINDOW_RST);
    g_lp = int'(LONG_PRESS_RST);
    g_rp = int'(REPEAT_RST);
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset register values: thresholds exact and one past, clicks, time wrap
    put_sample(LEVEL_RELEASED, 0);
    put_sample(LEVEL_PRESSED, 10);
    put_sample(LEVEL_PRESSED, 1000);
    put_sample(LEVEL_PRESSED, 1);
    put_sample(LEVEL_PRESSED, 100);
    put_sample(LEVEL_PRESSED, 1);
    put_sample(LEVEL_RELEASED, 88);
    put_sample(LEVEL_PRESSED, 100);
    put_sample(LEVEL_RELEASED, 50);
    put_sample(LEVEL_PRESSED, 50);
    put_sample(LEVEL_RELEASED, 50);
    put_sample(LEVEL_RELEASED, 350);
    put_sample(LEVEL_RELEASED, 1);
    put_sample(LEVEL_PRESSED, 32'hFFFF_FF00 - now_ms);
    put_sample(LEVEL_PRESSED, 32'h400);
    put_sample(LEVEL_RELEASED, 1);
    wait_idle();

    // disabled: samples leave the state alone
    write_regs(1'b0, int'(CLICK_WINDOW_RST), int'(LONG_PRESS_RST), int'(REPEAT_RST));
    put_sample(LEVEL_PRESSED, 32'h8000_0000);
    put_sample(LEVEL_PRESSED, 32'h7FFF_FFFF);
    put_sample(LEVEL_RELEASED, 5);
    wait_idle();

    // zero thresholds
    write_regs(1'b1, 0, 0, 0);
    put_sample(LEVEL_PRESSED, 3);
    put_sample(LEVEL_PRESSED, 1);
    put_sample(LEVEL_PRESSED, 0);
    put_sample(LEVEL_PRESSED, 1);
    put_sample(LEVEL_RELEASED, 0);
    wait_idle();

    // maximum thresholds
    write_regs(1'b1, 'hFFFF, 'hFFFF, 'hFFFF);
    put_sample(LEVEL_PRESSED, 7);
    put_sample(LEVEL_PRESSED, 32'h0000_FFFF);
    put_sample(LEVEL_PRESSED, 1);
    put_sample(LEVEL_PRESSED, 32'h0000_FFFF);
    put_sample(LEVEL_PRESSED, 1);
    put_sample(LEVEL_RELEASED, 2);
    put_sample(LEVEL_RELEASED, 32'h0000_FFFF);
    wait_idle();

    // repeat counter wraps
    write_regs(1'b1, 'hFFFF, 0, 0);
    put_sample(LEVEL_PRESSED, 1);
    repeat (260) put_sample(LEVEL_PRESSED, 1);
    put_sample(LEVEL_RELEASED, 1);
    wait_idle();

    // push counter wraps to zero and is not reported
    in_idle_pct = 20;
    out_stall_pct = 20;
    put_sample(LEVEL_RELEASED, 32'h0002_0000);
    repeat (256) begin
      put_sample(LEVEL_PRESSED, 1);
      put_sample(LEVEL_RELEASED, 1);
    end
    put_sample(LEVEL_RELEASED, 32'h0001_1000);
    put_sample(LEVEL_PRESSED, 1);
    put_sample(LEVEL_RELEASED, 32'h0001_0000);
    wait_idle();

    while (n_items < ITEM_GOAL) begin
      write_regs($urandom_range(0, 7) != 0, pick_reg(), pick_reg(), pick_reg());
      in_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 60);
      out_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 60);
      if (!g_en) begin
        repeat (15) gesture();
      end else begin
        stop_at = n_items + $urandom_range(60, 160);
        while (n_items < stop_at) gesture();
      end
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bclr_pkg.sv
rtl/bclr_in_if.sv
rtl/bclr_out_if.sv
rtl/button_click_long_repeat_detector_top.sv
verif/tb_top.sv
